@@ design/mos_pkg.sv @@
package mos_pkg;

    localparam int MaxSamplesDefault = 64;
    localparam int SampleWidth = 32;
    localparam int MedianWidth = 33;
    localparam int CountWidth = 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_MID_A,
        ST_MID_B,
        ST_DONE
    } state_t;

    // Memory command issued by the controller to the sample store.
    typedef struct packed {
        logic        rd_en;
        logic [11:0] rd_addr;
        logic        wr_en;
        logic [11:0] wr_addr;
        logic [31:0] wr_data;
    } mem_cmd_t;

endpackage

@@ design/median_of_samples.sv @@
// Median of a set of signed Q16.16 samples.
// Input: start with sample and last_sample; an item is taken when start is
// high and busy is low. Samples are kept in ascending order in a one-port-read,
// one-port-write synchronous memory of MAX_SAMPLES entries.
// Each kept sample is inserted by walking down the memory: one read, then one
// write per entry moved; into an empty set it is written straight to entry 0.
// A dropped sample (store full) is not stored and sets the overflow flag.
// On the last item of a set, the middle entry (odd count) or the two middle
// entries (even count) are read; in the cycle after that done pulses for one
// cycle with median_twice, sample_count and overflow, and then the next item
// can be taken.
// The receiver cannot stall; the result is shown for that one cycle only.
// Reset clears the count and the overflow flag; the memory needs no clearing,
// since only entries below the count are ever read.
module median_of_samples
    import mos_pkg::*;
#(
    parameter int MAX_SAMPLES = MaxSamplesDefault
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [SampleWidth-1:0] sample,
    input  logic                   last_sample,
    output logic                   busy,
    output logic                   done,
    output logic [MedianWidth-1:0] median_twice,
    output logic [CountWidth-1:0]  sample_count,
    output logic                   overflow
);

    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

    mem_cmd_t cmd;
    logic [SampleWidth-1:0] rd_data;

    mos_ctrl #(.MAX_SAMPLES(MAX_SAMPLES)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .sample(sample),
        .last_sample(last_sample), .rd_data(rd_data), .cmd(cmd), .busy(busy),
        .done(done), .median_twice(median_twice), .sample_count(sample_count),
        .overflow(overflow)
    );

    mos_store #(.MAX_SAMPLES(MAX_SAMPLES)) u_store (
        .clk(clk), .rd_en(cmd.rd_en), .rd_addr(cmd.rd_addr[AW-1:0]),
        .wr_en(cmd.wr_en), .wr_addr(cmd.wr_addr[AW-1:0]), .wr_data(cmd.wr_data),
        .rd_data(rd_data)
    );

endmodule

@@ design/mos_store.sv @@
module mos_store
    import mos_pkg::*;
#(
    parameter int MAX_SAMPLES = MaxSamplesDefault,
    parameter int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1
)
(
    input  logic                   clk,
    input  logic                   rd_en,
    input  logic [AW-1:0]          rd_addr,
    input  logic                   wr_en,
    input  logic [AW-1:0]          wr_addr,
    input  logic [SampleWidth-1:0] wr_data,
    output logic [SampleWidth-1:0] rd_data
);

    logic [SampleWidth-1:0] mem [MAX_SAMPLES];

    // Single write port, single registered read port.
    // A read of the entry written in the same cycle returns the new data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data <= wr_data;
            end
            else
            begin
                rd_data <= mem[rd_addr];
            end
        end
    end

endmodule

@@ design/mos_ctrl.sv @@
module mos_ctrl
    import mos_pkg::*;
#(
    parameter int MAX_SAMPLES = MaxSamplesDefault,
    parameter int CW = $clog2(MAX_SAMPLES + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [SampleWidth-1:0] sample,
    input  logic                   last_sample,
    input  logic [SampleWidth-1:0] rd_data,
    output mem_cmd_t               cmd,
    output logic                   busy,
    output logic                   done,
    output logic [MedianWidth-1:0] median_twice,
    output logic [CountWidth-1:0]  sample_count,
    output logic                   overflow
);

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic dropped_reg, dropped_next;
    logic last_reg, last_next;
    logic signed [SampleWidth-1:0] val_reg, val_next;
    logic signed [SampleWidth-1:0] mid_reg, mid_next;
    logic [MedianWidth-1:0] med_reg, med_next;
    logic [CW-1:0] half;
    logic odd;
    logic accept;
    logic keep;

    assign accept = start && (state_reg == ST_IDLE);
    assign keep = (count_reg < CW'(MAX_SAMPLES));
    assign half = count_reg >> 1;
    assign odd = count_reg[0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (keep && count_reg != '0)
                        state_next = ST_SCAN;
                    else if (last_sample)
                        state_next = ST_MID_A;
                end
            end
            ST_SCAN:
            begin
                if ($signed(rd_data) > val_reg)
                    state_next = ST_SHIFT;
                else if (last_reg)
                    state_next = ST_MID_A;
                else
                    state_next = ST_IDLE;
            end
            ST_SHIFT:
            begin
                if (pos_reg != '0)
                    state_next = ST_SCAN;
                else if (last_reg)
                    state_next = ST_MID_A;
                else
                    state_next = ST_IDLE;
            end
            ST_MID_A: state_next = odd ? ST_DONE : ST_MID_B;
            ST_MID_B: state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory commands: insertion walks down, one read and one write per entry moved.
    always_comb
    begin
        count_next = count_reg;
        pos_next = pos_reg;
        dropped_next = dropped_reg;
        last_next = last_reg;
        val_next = val_reg;
        mid_next = mid_reg;
        med_next = med_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    val_next = sample;
                    last_next = last_sample;
                    if (keep)
                    begin
                        count_next = count_reg + 1'b1;
                        pos_next = count_reg;
                        if (count_reg == '0)
                        begin
                            cmd.wr_en = 1'b1;
                            cmd.wr_addr = '0;
                            cmd.wr_data = sample;
                        end
                        else
                        begin
                            cmd.rd_en = 1'b1;
                            cmd.rd_addr = 12'(count_reg - 1'b1);
                        end
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (last_sample && !(keep && count_reg != '0))
                    begin
                        cmd.rd_en = 1'b1;
                        cmd.rd_addr = 12'((count_next >> 1) - CW'(!count_next[0]));
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.wr_en = 1'b1;
                cmd.wr_addr = 12'(pos_reg);
                if ($signed(rd_data) > val_reg)
                begin
                    cmd.wr_data = rd_data;
                    pos_next = pos_reg - 1'b1;
                end
                else
                begin
                    cmd.wr_data = val_reg;
                    if (last_reg)
                    begin
                        cmd.rd_en = 1'b1;
                        cmd.rd_addr = 12'(half - CW'(!odd));
                    end
                end
            end
            ST_SHIFT:
            begin
                if (pos_reg != '0)
                begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_addr = 12'(pos_reg - 1'b1);
                end
                else
                begin
                    cmd.wr_en = 1'b1;
                    cmd.wr_addr = '0;
                    cmd.wr_data = val_reg;
                    if (last_reg)
                    begin
                        cmd.rd_en = 1'b1;
                        cmd.rd_addr = 12'(half - CW'(!odd));
                    end
                end
            end
            ST_MID_A:
            begin
                mid_next = rd_data;
                med_next = {rd_data, 1'b0};
                if (!odd)
                begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_addr = 12'(half);
                end
            end
            ST_MID_B:
            begin
                med_next = MedianWidth'({mid_reg[SampleWidth-1], mid_reg})
                    + MedianWidth'({rd_data[SampleWidth-1], rd_data});
            end
            ST_DONE:
            begin
                count_next = '0;
                dropped_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        last_reg <= last_next;
        val_reg <= val_next;
        mid_reg <= mid_next;
        med_reg <= med_next;
    end

    // Outputs.
    always_comb
    begin
        busy = (state_reg != ST_IDLE);
        done = (state_reg == ST_DONE);
        median_twice = med_reg;
        sample_count = CountWidth'(count_reg);
        overflow = dropped_reg;
    end

endmodule

@@ design/mos_checker.sv @@
module mos_checker
    import mos_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  done,
    input logic [CountWidth-1:0] sample_count
);

    // A result only ends a busy stretch.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("done without busy");

    // After a result the block is free for the next item.
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy) else $error("busy after done");

    // A result never reports an empty set.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> sample_count != '0) else $error("empty count");

    // Results are single-cycle pulses.
    a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");

    // Busy only rises after an item was taken.
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start)) else $error("busy without start");

endmodule

bind median_of_samples mos_checker u_mos_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .sample_count(sample_count)
);

@@ dv/median_of_samples_test.sv @@
module median_of_samples_test;
    import mos_pkg::*;

    localparam int Capacity = MaxSamplesDefault;
    localparam int StallLimit = 20000;

    // Tracks the sorted set and the medians expected from the block.
    class median_scoreboard;
        logic signed [SampleWidth-1:0] kept[$];
        bit dropped;
        logic [MedianWidth-1:0] median_q[$];
        logic [CountWidth-1:0] count_q[$];
        bit overflow_q[$];
        int mismatches;

        function void note_item(logic signed [SampleWidth-1:0] value, bit is_last);
            int pos;
            int n;
            logic signed [MedianWidth-1:0] twice;
            if (kept.size() < Capacity)
            begin
                pos = kept.size();
                while (pos > 0 && kept[pos-1] > value)
                    pos--;
                kept.insert(pos, value);
            end
            else
                dropped = 1;
            if (!is_last)
                return;
            n = kept.size();
            if (n % 2 == 1)
                twice = MedianWidth'(kept[n/2]) <<< 1;
            else
                twice = MedianWidth'(kept[n/2-1]) + MedianWidth'(kept[n/2]);
            median_q.push_back(twice);
            count_q.push_back(CountWidth'(n));
            overflow_q.push_back(dropped);
            kept.delete();
            dropped = 0;
        endfunction

        function void check_result(logic [MedianWidth-1:0] med,
                                   logic [CountWidth-1:0] cnt, logic ovf);
            if (median_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: median %h count %0d", med, cnt);
                return;
            end
            if (med !== median_q[0] || cnt !== count_q[0] || ovf !== overflow_q[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                             median_q[0], count_q[0], overflow_q[0], med, cnt, ovf);
            end
            void'(median_q.pop_front());
            void'(count_q.pop_front());
            void'(overflow_q.pop_front());
        endfunction

        function int pending();
            return median_q.size();
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic [SampleWidth-1:0] sample = '0;
    logic last_sample = 0;
    logic busy, done;
    logic [MedianWidth-1:0] median_twice;
    logic [CountWidth-1:0] sample_count;
    logic overflow;

    median_scoreboard board = new();
    int idle_cycles;
    bit allow_gaps = 1;

    median_of_samples dut (
        .clk(clk), .rst_n(rst_n), .start(start), .sample(sample),
        .last_sample(last_sample), .busy(busy), .done(done),
        .median_twice(median_twice), .sample_count(sample_count),
        .overflow(overflow)
    );

    always #5 clk = ~clk;

    // Check results and watch for a stalled run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                board.check_result(median_twice, sample_count, overflow);
            if (done || (start && !busy))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= StallLimit)
            begin
                $display("FAIL median_of_samples");
                $finish;
            end
        end
    end

    // Present one item and wait for it to be taken; start stays high after
    // the item is taken so that a following item can go back to back.
    task automatic send_item(logic [SampleWidth-1:0] value, bit is_last);
        int gap;
        if (allow_gaps && $urandom_range(0, 3) == 0)
        begin
            start <= 0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(posedge clk);
        end
        start <= 1;
        sample <= value;
        last_sample <= is_last;
        do
            @(posedge clk);
        while (busy);
        board.note_item(value, is_last);
    endtask

    // Stop offering items.
    task automatic stop_items();
        start <= 0;
    endtask

    function automatic logic [SampleWidth-1:0] random_sample();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 7) - 4;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_set(int len);
        for (int i = 0; i < len; i++)
            send_item(random_sample(), i == len - 1);
    endtask

    initial
    begin
        int len;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: single samples at the extremes, pairs, a duplicate set.
        send_item(32'h7fff_ffff, 1);
        send_item(32'h8000_0000, 1);
        send_item(32'h7fff_ffff, 0);
        send_item(32'h7fff_ffff, 1);
        send_item(32'h8000_0000, 0);
        send_item(32'h8000_0000, 1);
        send_item(32'h7fff_ffff, 0);
        send_item(32'h8000_0000, 0);
        send_item(32'h0000_0001, 1);
        send_item(32'h0001_0000, 0);
        send_item(32'hffff_0000, 0);
        send_item(32'h0000_0000, 0);
        send_item(32'h0001_0000, 1);
        stop_items();

        // Wait for every result before moving on.
        while (board.pending() != 0)
            @(posedge clk);

        // Store full: exactly capacity, then with drops including the last.
        send_set(Capacity);
        send_set(Capacity + 3);

        // Random sets, mostly short, a few around or past capacity.
        while (board.median_q.size() + 0 >= 0 && len < 1100)
        begin
            int n;
            if ($urandom_range(0, 19) == 0)
                n = $urandom_range(Capacity - 1, Capacity + 4);
            else
                n = $urandom_range(1, 12);
            if (len > 900)
                allow_gaps = 0;
            send_set(n);
            len += n;
        end
        stop_items();

        while (board.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (board.mismatches == 0 && board.kept.size() == 0)
            $display("PASS median_of_samples");
        else
            $display("FAIL median_of_samples");
        $finish;
    end
endmodule
